[hw/rtl/fcfc_pkg.sv]
// Shared constants for the friction cone force clamp.
package fcfc_pkg;

    // Default component width of a packed force or point vector
    localparam int COMPONENT_BITS_DEF = 21;

    // Fixed field widths of the stream words
    localparam int FLIP_W  = 4;
    localparam int VEC_W   = 63;
    localparam int NZ_W    = 16;
    localparam int CFG_W   = 24;
    localparam int TUSER_W = 5;

    // Packed input word: contact, prior, normal, support, slip, traction
    localparam int IN_FIELDS_W = 5 * VEC_W + NZ_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Packed output word: apply point, support, slip, traction, total
    localparam int OUT_FIELDS_W = 5 * VEC_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRICTION = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CLIMB    = 1'd1;

    // Register reset values (unsigned Q8.16)
    localparam logic [CFG_W-1:0] FRICTION_RST = 24'd65536;
    localparam logic [CFG_W-1:0] CLIMB_RST    = 24'd0;

    // Fixed-point ones
    localparam int ONE_Q14 = 16384;
    localparam int ONE_Q16 = 65536;

endpackage

[hw/rtl/friction_cone_force_clamp.sv]
// Friction cone force clamp: pipelined cone projection of one contact patch per word.
//
// Input stream (s_*): one contact patch per word, taken when s_tvalid and s_tready are high.
// Output stream (m_*): one result word per input word, in order, held while m_tready is low.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_addr
// (0 friction coefficient, 1 climb gain, both unsigned Q8.16); write only while idle.
// Throughput: one word per cycle while the output word is not stalled. Every stage
// advances together; the two norms come from a digit-serial square root with one
// result bit per stage, and the cone scaling from nine restoring divider lanes with
// one quotient bit per stage.
// When the output register holds a word that is not taken, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults (friction 1.0, climb 0).
// A word whose three force vectors are all zero comes out with force_valid low and all
// force fields zero; the point and flipper index still pass through.
// Vectors pack x, y, z as signed Q(COMPONENT_BITS-6).6 from the low bit up; bits above
// three components are ignored on input and zero on output.
module friction_cone_force_clamp #(
    parameter int COMPONENT_BITS = fcfc_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // cfg
    input  logic                                 cfg_we,
    input  logic [fcfc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fcfc_pkg::CFG_W-1:0]           cfg_wdata,
    // slave side
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // contact_point, prior_point, normal_up, support_force, slip_force,
    // traction_force, zero pad
    input  logic [fcfc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // flipper_index, contact_ok
    input  logic [fcfc_pkg::TUSER_W-1:0]         s_tuser,
    // master side
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // apply_point, support_out, slip_out, traction_out, total_force, zero pad
    output logic [fcfc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // out_flipper, force_valid
    output logic [fcfc_pkg::TUSER_W-1:0]         m_tuser
);

    localparam int CB    = COMPONENT_BITS;
    localparam int TW    = CB + 1;             // tangential sum width
    localparam int N2W   = 2 * CB + 2;         // sum of squares width
    localparam int RW    = CB + 9;             // norm width (Q.14)
    localparam int RADW  = 2 * RW;             // radicand width
    localparam int MW    = 26;                 // 1 + climb term (Q.16)
    localparam int MUW   = 34;                 // effective friction (Q.16)
    localparam int LW    = MUW - 16 + RW + 1;  // limit width
    localparam int QW    = TW;                 // quotient width
    localparam int NUMW  = TW + RW;            // dividend width
    localparam int VW    = fcfc_pkg::VEC_W;
    localparam int NL    = 9;                  // divider lanes

    // Pipeline stage positions
    localparam int SQ0_I = 2;
    localparam int L1_I  = SQ0_I + RW;
    localparam int L2_I  = L1_I + 1;
    localparam int M_I   = L2_I + 1;
    localparam int DV0_I = M_I + 1;
    localparam int OUT_I = DV0_I + QW;

    typedef struct packed {
        logic [fcfc_pkg::FLIP_W-1:0] flip;
        logic                        any;
        logic [VW-1:0]               apply;
        logic [2:0][CB-1:0]          sup;
        logic [2:0][CB-1:0]          slp;
        logic [2:0][CB-1:0]          trc;
        logic [2:0][TW-1:0]          tan;
    } carry_t;

    typedef struct packed {
        logic [RADW-1:0] rad_n;
        logic [RADW-1:0] rad_t;
        logic [RW:0]     rem_n;
        logic [RW:0]     rem_t;
        logic [RW-1:0]   root_n;
        logic [RW-1:0]   root_t;
        logic [MUW-1:0]  mu;
    } sq_t;

    typedef struct packed {
        logic [NL-1:0][NUMW-1:0] num;
        logic [NL-1:0][RW-1:0]   rem;
        logic [NL-1:0][QW-1:0]   quo;
        logic [NL-1:0]           neg;
        logic                    scale;
        logic [RW-1:0]           ft;
    } dv_t;

    // One restoring square root step: returns {rem, root}
    function automatic logic [2*RW:0] sq_step(input logic [RW:0] rem,
                                              input logic [RW-1:0] root,
                                              input logic [1:0] pair);
        logic [RW+2:0] acc;
        logic [RW+2:0] trial;
        logic [RW+2:0] diff;
        acc   = {rem, pair};
        trial = {1'b0, root, 2'b01};
        diff  = acc - trial;
        if (acc >= trial)
            sq_step = {diff[RW:0], root[RW-2:0], 1'b1};
        else
            sq_step = {acc[RW:0], root[RW-2:0], 1'b0};
    endfunction

    // One restoring division step: returns {quotient bit, rem}
    function automatic logic [RW:0] dv_step(input logic [RW-1:0] rem,
                                            input logic nb,
                                            input logic [RW-1:0] den);
        logic [RW:0] acc;
        logic [RW:0] diff;
        acc  = {rem, nb};
        diff = acc - {1'b0, den};
        if (acc >= {1'b0, den})
            dv_step = {1'b1, diff[RW-1:0]};
        else
            dv_step = {1'b0, acc[RW-1:0]};
    endfunction

    logic                        adv;
    logic [OUT_I-1:0]            v_reg;
    carry_t                      car_reg [OUT_I];
    logic [fcfc_pkg::CFG_W-1:0]  fc_reg;
    logic [fcfc_pkg::CFG_W-1:0]  cg_reg;

    // Advance every stage unless the output word is stalled
    assign adv      = ~m_tvalid | m_tready;
    assign s_tready = adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= fcfc_pkg::FRICTION_RST;
            cg_reg <= fcfc_pkg::CLIMB_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fcfc_pkg::REG_FRICTION: fc_reg <= cfg_wdata;
                fcfc_pkg::REG_CLIMB:    cg_reg <= cfg_wdata;
                default:                fc_reg <= fc_reg;
            endcase
        end
    end

    // Valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[OUT_I-2:0], s_tvalid};
    end

    // Stage 0: unpack, form tangential sum, pick point, groundness
    carry_t            car_in;
    logic [14:0]       steep_next;
    logic [14:0]       steep_reg;
    logic signed [15:0] nz;
    logic [14:0]       gnd;

    always_comb
    begin
        car_in.flip  = s_tuser[3:0];
        car_in.apply = '0;
        car_in.apply[3*CB-1:0] = s_tuser[4] ? s_tdata[3*CB-1:0]
                                            : s_tdata[VW +: 3*CB];
        for (int i = 0; i < 3; i++)
        begin
            car_in.sup[i] = s_tdata[2*VW + 16 + i*CB +: CB];
            car_in.slp[i] = s_tdata[3*VW + 16 + i*CB +: CB];
            car_in.trc[i] = s_tdata[4*VW + 16 + i*CB +: CB];
            car_in.tan[i] = TW'($signed(car_in.slp[i])) + TW'($signed(car_in.trc[i]));
        end
        car_in.any = (|car_in.sup) | (|car_in.slp) | (|car_in.trc);
        nz = $signed(s_tdata[2*VW +: 16]);
        if (nz[15])
            gnd = '0;
        else if (nz > 16'sd16384)
            gnd = 15'(fcfc_pkg::ONE_Q14);
        else
            gnd = nz[14:0];
        steep_next = 15'(fcfc_pkg::ONE_Q14) - gnd;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            car_reg[0] <= car_in;
            steep_reg  <= steep_next;
        end
    end

    // Shift the carried fields down the pipe
    for (genvar s = 1; s < OUT_I; s++) begin : g_carry
        always_ff @(posedge clk)
        begin
            if (adv)
                car_reg[s] <= car_reg[s-1];
        end
    end

    // Stage 1: squares and climb term
    logic [N2W-1:0] n2n_next, n2t_next, n2n_reg, n2t_reg;
    logic [MW-1:0]  m_next, m_reg;
    logic [38:0]    climb_prod;
    logic signed [2*CB-1:0] sq_sup [3];
    logic signed [2*TW-1:0] sq_tan [3];

    always_comb
    begin
        n2n_next = '0;
        n2t_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            sq_sup[i] = $signed(car_reg[0].sup[i]) * $signed(car_reg[0].sup[i]);
            sq_tan[i] = $signed(car_reg[0].tan[i]) * $signed(car_reg[0].tan[i]);
            n2n_next  = n2n_next + N2W'(unsigned'(sq_sup[i]));
            n2t_next  = n2t_next + N2W'(unsigned'(sq_tan[i]));
        end
        climb_prod = 39'(cg_reg) * 39'(steep_reg);
        m_next     = MW'(fcfc_pkg::ONE_Q16) + MW'(climb_prod[38:14]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n2n_reg <= n2n_next;
            n2t_reg <= n2t_next;
            m_reg   <= m_next;
        end
    end

    // Square root stages: one root bit per stage for both norms
    sq_t sq_in  [RW];
    sq_t sq_nxt [RW];
    sq_t sq_reg [RW];
    logic [49:0] mu_prod;

    always_comb
    begin
        mu_prod         = 50'(fc_reg) * 50'(m_reg);
        sq_in[0].rad_n  = {n2n_reg, 16'd0};
        sq_in[0].rad_t  = {n2t_reg, 16'd0};
        sq_in[0].rem_n  = '0;
        sq_in[0].rem_t  = '0;
        sq_in[0].root_n = '0;
        sq_in[0].root_t = '0;
        sq_in[0].mu     = mu_prod[49:16];
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        if (k > 0) begin : g_link
            assign sq_in[k] = sq_reg[k-1];
        end

        always_comb
        begin
            sq_nxt[k] = sq_in[k];
            {sq_nxt[k].rem_n, sq_nxt[k].root_n} =
                sq_step(sq_in[k].rem_n, sq_in[k].root_n, sq_in[k].rad_n[2*(RW-1-k) +: 2]);
            {sq_nxt[k].rem_t, sq_nxt[k].root_t} =
                sq_step(sq_in[k].rem_t, sq_in[k].root_t, sq_in[k].rad_t[2*(RW-1-k) +: 2]);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                sq_reg[k] <= sq_nxt[k];
        end
    end

    // Limit stage 1: split product of friction and support norm
    logic [MUW-16+RW-1:0] phi_reg;
    logic [16+RW-1:0]     plo_reg;
    logic [RW-1:0]        ft1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phi_reg <= (MUW-16+RW)'(sq_reg[RW-1].mu[MUW-1:16]) * (MUW-16+RW)'(sq_reg[RW-1].root_n);
            plo_reg <= (16+RW)'(sq_reg[RW-1].mu[15:0]) * (16+RW)'(sq_reg[RW-1].root_n);
            ft1_reg <= sq_reg[RW-1].root_t;
        end
    end

    // Limit stage 2: sum and cone test
    logic [LW-1:0] lim_next, lim_reg;
    logic          scale_reg;
    logic [RW-1:0] ft2_reg;

    assign lim_next = LW'(phi_reg) + LW'(plo_reg[16+RW-1:16]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lim_reg   <= lim_next;
            scale_reg <= LW'(ft1_reg) > lim_next;
            ft2_reg   <= ft1_reg;
        end
    end

    // Dividend stage: magnitude times limit for nine lanes
    dv_t                   dv_m;
    logic [NL-1:0][TW-1:0] lane_val;
    logic [TW-1:0]         lane_mag;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lane_val[i]   = TW'($signed(car_reg[L2_I].slp[i]));
            lane_val[3+i] = TW'($signed(car_reg[L2_I].trc[i]));
            lane_val[6+i] = car_reg[L2_I].tan[i];
        end
        dv_m.scale = scale_reg;
        dv_m.ft    = ft2_reg;
        for (int j = 0; j < NL; j++)
        begin
            dv_m.neg[j] = lane_val[j][TW-1];
            lane_mag    = lane_val[j][TW-1] ? (~lane_val[j] + TW'(1)) : lane_val[j];
            dv_m.num[j] = NUMW'(lane_mag) * NUMW'(lim_reg[RW-1:0]);
            dv_m.rem[j] = dv_m.num[j][NUMW-1:TW];
            dv_m.quo[j] = '0;
        end
    end

    dv_t dv_mreg;

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_mreg <= dv_m;
    end

    // Divider stages: one quotient bit per stage on every lane
    dv_t dv_in  [QW];
    dv_t dv_nxt [QW];
    dv_t dv_reg [QW];

    assign dv_in[0] = dv_mreg;

    for (genvar k = 0; k < QW; k++) begin : g_div
        if (k > 0) begin : g_link
            assign dv_in[k] = dv_reg[k-1];
        end

        always_comb
        begin
            logic [RW:0] st;
            dv_nxt[k] = dv_in[k];
            for (int j = 0; j < NL; j++)
            begin
                st = dv_step(dv_in[k].rem[j], dv_in[k].num[j][TW-1-k], dv_in[k].ft);
                dv_nxt[k].rem[j] = st[RW-1:0];
                dv_nxt[k].quo[j] = {dv_in[k].quo[j][QW-2:0], st[RW]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[k] <= dv_nxt[k];
        end
    end

    // Output stage: sign, select, saturate, pack
    localparam logic signed [TW:0] SAT_HI = (TW+1)'((1 << (CB-1)) - 1);
    localparam logic signed [TW:0] SAT_LO = -SAT_HI - (TW+1)'(1);

    carry_t                 cf;
    dv_t                    df;
    logic [NL-1:0][TW-1:0]  sq_val;
    logic [TW-1:0]          tan_f;
    logic signed [TW:0]     tot;
    logic [CB-1:0]          tot_c;
    logic [fcfc_pkg::OUT_TDATA_W-1:0] tdata_next, tdata_reg;
    logic [fcfc_pkg::TUSER_W-1:0]     tuser_next, tuser_reg;
    logic                             out_v_reg;

    always_comb
    begin
        cf = car_reg[OUT_I-1];
        df = dv_reg[QW-1];
        tdata_next = '0;
        tdata_next[VW-1:0] = cf.apply;
        for (int j = 0; j < NL; j++)
            sq_val[j] = df.neg[j] ? (~df.quo[j] + TW'(1)) : df.quo[j];
        for (int i = 0; i < 3; i++)
        begin
            tan_f = df.scale ? sq_val[6+i] : cf.tan[i];
            tot   = (TW+1)'($signed(cf.sup[i])) + (TW+1)'($signed(tan_f));
            priority if (tot > SAT_HI)
                tot_c = SAT_HI[CB-1:0];
            else if (tot < SAT_LO)
                tot_c = SAT_LO[CB-1:0];
            else
                tot_c = tot[CB-1:0];
            if (cf.any)
            begin
                tdata_next[VW   + i*CB +: CB] = cf.sup[i];
                tdata_next[2*VW + i*CB +: CB] = df.scale ? sq_val[i][CB-1:0]   : cf.slp[i];
                tdata_next[3*VW + i*CB +: CB] = df.scale ? sq_val[3+i][CB-1:0] : cf.trc[i];
                tdata_next[4*VW + i*CB +: CB] = tot_c;
            end
        end
        tuser_next = {cf.any, cf.flip};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= v_reg[OUT_I-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

`ifndef SYNTHESIS
    // A new output word comes only from a valid last stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(v_reg[OUT_I-1]))
        else $error("output word without a source word");

    // A stalled last stage keeps its word
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[OUT_I-1] && !adv) |=> v_reg[OUT_I-1])
        else $error("stalled word dropped");

    // An invalid result carries no force
    a_zero_forces: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[4]) |-> (m_tdata[fcfc_pkg::OUT_TDATA_W-1:VW] == '0))
        else $error("force fields nonzero on invalid result");

    // Scaling is chosen only when the tangential norm exceeds the limit
    a_scale_cone: assert property (@(posedge clk) disable iff (!rst_n)
        scale_reg |-> (lim_reg < LW'(ft2_reg)))
        else $error("scaling chosen inside the cone");
`endif

endmodule
